### design/scno_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the segment/circle nearest obstacle unit.
// No dependencies.
package scno_pkg;

  localparam int ENTRIES_DEF = 32;

  localparam int COORD_W = 16;
  localparam int RAD_W   = 13;
  localparam int KIND_W  = 2;
  localparam int OIDX_W  = 5;

  // item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // obstacle kinds
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SOLID = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HOLE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BALL  = 2'd3;

  // one table entry, as stored in the memory
  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [RAD_W-1:0]          radius;
  } entry_t;

  // query context, held for the whole scan
  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic signed [COORD_W:0]   dx;
    logic signed [COORD_W:0]   dy;
    logic [RAD_W-1:0]          margin;
    logic                      avoid;
  } query_ctx_t;

  // per-entry verdict from the evaluation pipeline
  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic                 last;
    logic [2*COORD_W:0]   sqd;   // squared start-to-centre distance
  } eval_res_t;

endpackage

### design/scno_table.sv
`timescale 1ns / 1ps
// Obstacle table: single synchronous memory, one write and one read port.
// Depends on scno_pkg.
module scno_table import scno_pkg::*; #(
  parameter int  ENTRIES = ENTRIES_DEF,
  localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/scno_eval.sv
`timescale 1ns / 1ps
// Per-entry segment/circle test pipeline: differences, products, sums,
// compares, then the exact overlap test. Depends on scno_pkg.
module scno_eval import scno_pkg::*; #(
  parameter int  ENTRIES = ENTRIES_DEF,
  localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  query_ctx_t    ctx,
  input  logic          iss_valid,
  input  logic          iss_last,
  input  logic [IW-1:0] iss_idx,
  input  entry_t        rd_data,
  output eval_res_t     res,
  output logic [IW-1:0] res_idx
);

  localparam int NS = 8;  // memory read + seven compute stages

  logic [NS-1:0] vld_r;
  logic [NS-1:0] lst_r;
  logic [IW-1:0] tag_r [NS];

  // tag pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NS-2:0], iss_valid};
    end
  end

  always_ff @(posedge clk) begin
    lst_r    <= {lst_r[NS-2:0], iss_last};
    tag_r[0] <= iss_idx;
    for (int i = 1; i < NS; i++) begin
      tag_r[i] <= tag_r[i-1];
    end
  end

  // stage A: offsets and grown radius
  logic               use_nxt, ball_nxt;
  logic signed [16:0] wx_nxt, wy_nxt, fx_nxt, fy_nxt;
  logic [13:0]        rm_nxt;

  always_comb begin
    use_nxt  = (rd_data.kind == KIND_SOLID) ||
               ((rd_data.kind == KIND_BALL) && ctx.avoid);
    ball_nxt = (rd_data.kind == KIND_BALL);
    wx_nxt   = {rd_data.x[15], rd_data.x} - {ctx.sx[15], ctx.sx};
    wy_nxt   = {rd_data.y[15], rd_data.y} - {ctx.sy[15], ctx.sy};
    fx_nxt   = {ctx.ex[15], ctx.ex} - {rd_data.x[15], rd_data.x};
    fy_nxt   = {ctx.ey[15], ctx.ey} - {rd_data.y[15], rd_data.y};
    rm_nxt   = {1'b0, rd_data.radius} + {1'b0, ctx.margin};
  end

  logic [1:0]         ub_a_r;
  logic signed [16:0] wx_a_r, wy_a_r, fx_a_r, fy_a_r;
  logic [13:0]        rm_a_r;
  logic [12:0]        rad_a_r;

  always_ff @(posedge clk) begin
    ub_a_r  <= {use_nxt, ball_nxt};
    wx_a_r  <= wx_nxt;
    wy_a_r  <= wy_nxt;
    fx_a_r  <= fx_nxt;
    fy_a_r  <= fy_nxt;
    rm_a_r  <= rm_nxt;
    rad_a_r <= rd_data.radius;
  end

  // stage B: all products, in parallel
  logic [1:0]         ub_b_r;
  logic signed [33:0] wxx_b_r, wyy_b_r, fxx_b_r, fyy_b_r;
  logic signed [33:0] dwx_b_r, dwy_b_r, dfx_b_r, dfy_b_r;
  logic signed [33:0] dxx_b_r, dyy_b_r;
  logic [27:0]        big_b_r;
  logic [25:0]        r2_b_r;

  always_ff @(posedge clk) begin
    ub_b_r  <= ub_a_r;
    wxx_b_r <= wx_a_r * wx_a_r;
    wyy_b_r <= wy_a_r * wy_a_r;
    fxx_b_r <= fx_a_r * fx_a_r;
    fyy_b_r <= fy_a_r * fy_a_r;
    dwx_b_r <= ctx.dx * wx_a_r;
    dwy_b_r <= ctx.dy * wy_a_r;
    dfx_b_r <= ctx.dx * fx_a_r;
    dfy_b_r <= ctx.dy * fy_a_r;
    dxx_b_r <= ctx.dx * ctx.dx;
    dyy_b_r <= ctx.dy * ctx.dy;
    big_b_r <= rm_a_r * rm_a_r;
    r2_b_r  <= rad_a_r * rad_a_r;
  end

  // stage C: sums
  logic [1:0]         ub_c_r;
  logic [32:0]        s2_c_r, e2_c_r, len2_c_r;
  logic signed [34:0] dw_c_r, de_c_r;
  logic [27:0]        big_c_r;
  logic [25:0]        r2_c_r;

  always_ff @(posedge clk) begin
    ub_c_r   <= ub_b_r;
    s2_c_r   <= wxx_b_r[32:0] + wyy_b_r[32:0];
    e2_c_r   <= fxx_b_r[32:0] + fyy_b_r[32:0];
    len2_c_r <= dxx_b_r[32:0] + dyy_b_r[32:0];
    dw_c_r   <= 35'(dwx_b_r) + 35'(dwy_b_r);
    de_c_r   <= 35'(dfx_b_r) + 35'(dfy_b_r);
    big_c_r  <= big_b_r;
    r2_c_r   <= r2_b_r;
  end

  // stage D: compares, radius choice, endpoint rule
  logic        grow_nxt, dwpos_nxt, beyond_nxt, inside_nxt, cond_nxt;
  logic [27:0] g2_nxt;

  always_comb begin
    grow_nxt   = (s2_c_r > {5'b0, big_c_r}) && (e2_c_r > {5'b0, big_c_r});
    g2_nxt     = grow_nxt ? big_c_r : {2'b0, r2_c_r};
    dwpos_nxt  = !dw_c_r[34] && (dw_c_r != '0);
    beyond_nxt = !de_c_r[34];
    inside_nxt = e2_c_r < {7'b0, r2_c_r};
    cond_nxt   = ub_c_r[1] && dwpos_nxt && (beyond_nxt || (!ub_c_r[0] && inside_nxt));
  end

  logic        cond_d_r;
  logic [27:0] g2_d_r;
  logic [32:0] s2_d_r, len2_d_r, dwu_d_r;

  always_ff @(posedge clk) begin
    cond_d_r <= cond_nxt;
    g2_d_r   <= g2_nxt;
    s2_d_r   <= s2_c_r;
    len2_d_r <= len2_c_r;
    dwu_d_r  <= dw_c_r[32:0];
  end

  // stage E: squared distance minus squared radius
  logic [33:0] diff_nxt;

  assign diff_nxt = {1'b0, s2_d_r} - {6'b0, g2_d_r};

  logic        cond_e_r, dpos_e_r;
  logic [32:0] diff_e_r, s2_e_r, len2_e_r, dwu_e_r;

  always_ff @(posedge clk) begin
    cond_e_r <= cond_d_r;
    dpos_e_r <= !diff_nxt[33] && (diff_nxt != '0);
    diff_e_r <= diff_nxt[32:0];
    s2_e_r   <= s2_d_r;
    len2_e_r <= len2_d_r;
    dwu_e_r  <= dwu_d_r;
  end

  // stage F: wide products for the division-free overlap test
  logic        cond_f_r, dpos_f_r;
  logic [65:0] lhs_f_r, rhs_f_r;
  logic [32:0] s2_f_r;

  always_ff @(posedge clk) begin
    cond_f_r <= cond_e_r;
    dpos_f_r <= dpos_e_r;
    lhs_f_r  <= dwu_e_r * dwu_e_r;
    rhs_f_r  <= len2_e_r * diff_e_r;
    s2_f_r   <= s2_e_r;
  end

  // stage G: verdict
  logic        hit_g_r;
  logic [32:0] s2_g_r;

  always_ff @(posedge clk) begin
    hit_g_r <= cond_f_r && (!dpos_f_r || (lhs_f_r > rhs_f_r));
    s2_g_r  <= s2_f_r;
  end

  always_comb begin
    res.valid = vld_r[NS-1];
    res.last  = lst_r[NS-1];
    res.hit   = hit_g_r;
    res.sqd   = s2_g_r;
    res_idx   = tag_r[NS-1];
  end

endmodule

### design/segment_circle_nearest_obstacle_unit.sv
`timescale 1ns / 1ps
// Top level of the segment/circle nearest obstacle unit: control, query
// context, nearest-hit tracking. Depends on scno_pkg, scno_table, scno_eval.
//
// Usage
//   Input items are taken with start while busy is low. in_func selects a
//   table write (entry_index, obj_x, obj_y, obj_radius, obj_kind) or a segment
//   query (start/end point, margin, avoid_ball).
//   A write is stored at the transfer edge and busy stays low: a new item can
//   follow in the very next cycle. Writes to an index at or above ENTRIES are
//   dropped. Writes produce no result.
//   A query scans the table one entry per cycle through the single read port
//   of the table memory into an eight-register evaluation pipeline. busy is
//   high through the scan and the pipeline drain, so no new item is taken
//   while a query is in flight. out_valid pulses in the cycle in which busy
//   falls, and the next item can be taken in that same cycle.
//   The result (out_found, out_closest_index) is valid only while out_valid
//   is high; the receiver cannot stall, so it must take the transfer then.
//   out_closest_index is 0 when nothing blocks the segment.
// Reset
//   After rst_n the block runs a clearing pass that marks every entry empty,
//   one entry per cycle; busy stays high until the pass is done.
module segment_circle_nearest_obstacle_unit import scno_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_func,
  input  logic [OIDX_W-1:0]         in_entry_index,
  input  logic signed [COORD_W-1:0] in_obj_x,
  input  logic signed [COORD_W-1:0] in_obj_y,
  input  logic [RAD_W-1:0]          in_obj_radius,
  input  logic [KIND_W-1:0]         in_obj_kind,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic signed [COORD_W-1:0] in_end_x,
  input  logic signed [COORD_W-1:0] in_end_y,
  input  logic                      in_avoid_ball,
  input  logic [RAD_W-1:0]          in_margin,
  output logic                      out_valid,
  output logic                      out_found,
  output logic [OIDX_W-1:0]         out_closest_index
);

  localparam int            IW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  query_ctx_t    ctx_r;

  logic accept, acc_query, acc_write;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign acc_query = accept && (in_func == FUNC_QUERY);
  assign acc_write = accept && (in_func == FUNC_WRITE) &&
                     (32'(in_entry_index) < 32'(ENTRIES));

  eval_res_t     ev;
  logic [IW-1:0] ev_idx;

  // sequencer: clearing pass, scan, pipeline drain
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (acc_query) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (ev.valid && ev.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // query context is held steady for the whole scan
  always_ff @(posedge clk) begin
    if (acc_query) begin
      ctx_r.sx     <= in_start_x;
      ctx_r.sy     <= in_start_y;
      ctx_r.ex     <= in_end_x;
      ctx_r.ey     <= in_end_y;
      ctx_r.dx     <= {in_end_x[15], in_end_x} - {in_start_x[15], in_start_x};
      ctx_r.dy     <= {in_end_y[15], in_end_y} - {in_start_y[15], in_start_y};
      ctx_r.margin <= in_margin;
      ctx_r.avoid  <= in_avoid_ball;
    end
  end

  // table port muxing: clearing pass owns the write port after reset
  logic          mem_wr_en;
  logic [IW-1:0] mem_wr_addr;
  entry_t        mem_wr_data;
  entry_t        mem_rd_data;
  logic          clearing;

  always_comb begin
    clearing    = (state_r == ST_CLEAR);
    mem_wr_en   = clearing || acc_write;
    mem_wr_addr = clearing ? cnt_r : IW'(in_entry_index);
    mem_wr_data = '0;
    if (!clearing) begin
      mem_wr_data.kind   = in_obj_kind;
      mem_wr_data.x      = in_obj_x;
      mem_wr_data.y      = in_obj_y;
      mem_wr_data.radius = in_obj_radius;
    end
  end

  scno_table #(.ENTRIES(ENTRIES)) u_table (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (state_r == ST_SCAN),
    .rd_addr (cnt_r),
    .rd_data (mem_rd_data)
  );

  scno_eval #(.ENTRIES(ENTRIES)) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctx       (ctx_r),
    .iss_valid (state_r == ST_SCAN),
    .iss_last  (cnt_r == LAST_IDX),
    .iss_idx   (cnt_r),
    .rd_data   (mem_rd_data),
    .res       (ev),
    .res_idx   (ev_idx)
  );

  // nearest tracking: strict less-than keeps the lowest index on ties
  logic          best_found_r, best_found_nxt;
  logic [32:0]   best_dist_r, best_dist_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic          take;

  always_comb begin
    take           = ev.valid && ev.hit && (!best_found_r || (ev.sqd < best_dist_r));
    best_found_nxt = best_found_r || take;
    best_dist_nxt  = take ? ev.sqd : best_dist_r;
    best_idx_nxt   = take ? ev_idx : best_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
    end else if (acc_query) begin
      best_found_r <= 1'b0;
    end else begin
      best_found_r <= best_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_dist_r <= best_dist_nxt;
    best_idx_r  <= best_idx_nxt;
  end

  // result register, one-cycle strobe
  logic              out_valid_r;
  logic              out_found_r;
  logic [OIDX_W-1:0] out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ev.valid && ev.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.valid && ev.last) begin
      out_found_r <= best_found_nxt;
      out_idx_r   <= best_found_nxt ? OIDX_W'(best_idx_nxt) : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_closest_index = out_idx_r;

`ifndef ASSERT_OFF
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result transfer without a query in flight");

  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("more than one result per query");

  a_no_hit_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_closest_index == '0))
    else $error("nonzero index with no obstacle found");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc_query |=> busy)
    else $error("query transfer did not raise busy");

  a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (ev.valid && ev.last) |-> (state_r == ST_DRAIN))
    else $error("pipeline last entry out of step with sequencer");
`endif

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench for segment_circle_nearest_obstacle_unit: directed and random
// table writes and segment queries, checked against an in-bench predictor.
// Depends on scno_pkg and the unit's RTL.
module tb;
  import scno_pkg::*;

  // one input transfer, every field as driven on the in_ ports
  typedef struct {
    logic                      func;
    logic [OIDX_W-1:0]         index;
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic [RAD_W-1:0]          orad;
    logic [KIND_W-1:0]         okind;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic                      avoid;
    logic [RAD_W-1:0]          margin;
  } item_t;

  // predicted answer of one query
  typedef struct packed {
    logic              found;
    logic [OIDX_W-1:0] idx;
  } hit_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_func = FUNC_WRITE;
  logic [OIDX_W-1:0]         in_entry_index = '0;
  logic signed [COORD_W-1:0] in_obj_x = '0;
  logic signed [COORD_W-1:0] in_obj_y = '0;
  logic [RAD_W-1:0]          in_obj_radius = '0;
  logic [KIND_W-1:0]         in_obj_kind = KIND_EMPTY;
  logic signed [COORD_W-1:0] in_start_x = '0;
  logic signed [COORD_W-1:0] in_start_y = '0;
  logic signed [COORD_W-1:0] in_end_x = '0;
  logic signed [COORD_W-1:0] in_end_y = '0;
  logic                      in_avoid_ball = 1'b0;
  logic [RAD_W-1:0]          in_margin = '0;
  logic                      out_valid;
  logic                      out_found;
  logic [OIDX_W-1:0]         out_closest_index;

  // mirror of the obstacle table, updated at each write transfer
  entry_t obst_mirror [ENTRIES_DEF];
  // answers still owed by the unit, oldest first
  hit_t   pending_hits [$];

  int mismatches   = 0;
  int results_seen = 0;
  int n_writes     = 0;
  int n_queries    = 0;
  int n_blocked    = 0;

  segment_circle_nearest_obstacle_unit #(.ENTRIES(ENTRIES_DEF)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_entry_index    (in_entry_index),
    .in_obj_x          (in_obj_x),
    .in_obj_y          (in_obj_y),
    .in_obj_radius     (in_obj_radius),
    .in_obj_kind       (in_obj_kind),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_end_x          (in_end_x),
    .in_end_y          (in_end_y),
    .in_avoid_ball     (in_avoid_ball),
    .in_margin         (in_margin),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_closest_index (out_closest_index)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor: scan the mirrored table the way the unit does. All squared
  // terms fit in 64 bits; the overlap test products need up to 66 bits, so
  // they are formed at 128 bits.
  // ---------------------------------------------------------------------
  function automatic hit_t nearest_blocker(input item_t q);
    hit_t res;
    logic [KIND_W-1:0] kind;
    longint dx, dy, m, r, wx, wy, fx, fy, s2, e2, reach, grown;
    longint dw, len2, diff, best_s2;
    logic [127:0] dw_sq, len_diff;
    bit passes;
    res = '0;
    best_s2 = 0;
    dx = longint'(q.ex) - longint'(q.sx);
    dy = longint'(q.ey) - longint'(q.sy);
    m  = longint'(q.margin);
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      kind = obst_mirror[i].kind;
      if (kind == KIND_EMPTY || kind == KIND_HOLE) continue;
      if (kind == KIND_BALL && !q.avoid) continue;
      r  = longint'(obst_mirror[i].radius);
      wx = longint'($signed(obst_mirror[i].x)) - longint'(q.sx);
      wy = longint'($signed(obst_mirror[i].y)) - longint'(q.sy);
      fx = longint'(q.ex) - longint'($signed(obst_mirror[i].x));
      fy = longint'(q.ey) - longint'($signed(obst_mirror[i].y));
      s2 = wx * wx + wy * wy;
      e2 = fx * fx + fy * fy;
      // margin only applies when both endpoints clear the grown circle
      reach = r + m;
      grown = (s2 > reach * reach && e2 > reach * reach) ? reach : r;
      dw = dx * wx + dy * wy;
      if (dw <= 0) continue;   // centre behind start, or zero-length segment
      len2 = dx * dx + dy * dy;
      diff = s2 - grown * grown;
      if (diff > 0) begin
        dw_sq    = 128'(dw) * 128'(dw);
        len_diff = 128'(len2) * 128'(diff);
        if (dw_sq <= len_diff) continue;
      end
      // segment must reach past the centre; solids also block when the
      // end point lands inside the plain radius
      passes = (dx * fx + dy * fy) >= 0;
      if (kind != KIND_BALL && e2 < r * r) passes = 1'b1;
      if (!passes) continue;
      if (!res.found || s2 < best_s2) begin
        res.found = 1'b1;
        res.idx   = OIDX_W'(i);
        best_s2   = s2;
      end
    end
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp16(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic longint near_point(input longint c, input int spread);
    return c + longint'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  // all fields random, so fields the function ignores still toggle
  function automatic item_t noise_item();
    item_t it;
    it.func   = 1'($urandom);
    it.index  = OIDX_W'($urandom);
    it.ox     = COORD_W'($urandom);
    it.oy     = COORD_W'($urandom);
    it.orad   = RAD_W'($urandom);
    it.okind  = KIND_W'($urandom);
    it.sx     = COORD_W'($urandom);
    it.sy     = COORD_W'($urandom);
    it.ex     = COORD_W'($urandom);
    it.ey     = COORD_W'($urandom);
    it.avoid  = 1'($urandom);
    it.margin = RAD_W'($urandom);
    return it;
  endfunction

  function automatic item_t write_item(input int idx, input longint x, input longint y,
                                       input int rad, input logic [KIND_W-1:0] kind);
    item_t it;
    it       = noise_item();
    it.func  = FUNC_WRITE;
    it.index = OIDX_W'(idx);
    it.ox    = clamp16(x);
    it.oy    = clamp16(y);
    it.orad  = RAD_W'(rad);
    it.okind = kind;
    return it;
  endfunction

  function automatic item_t query_item(input longint sx, input longint sy, input longint ex,
                                       input longint ey, input bit avoid, input int margin);
    item_t it;
    it        = noise_item();
    it.func   = FUNC_QUERY;
    it.sx     = clamp16(sx);
    it.sy     = clamp16(sy);
    it.ex     = clamp16(ex);
    it.ey     = clamp16(ey);
    it.avoid  = avoid;
    it.margin = RAD_W'(margin);
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // Sender. start stays high between back-to-back items; only pause_sender
  // and wait_drained lower it, always in a step of their own.
  // ---------------------------------------------------------------------
  task automatic send_item(input item_t it);
    in_func        <= it.func;
    in_entry_index <= it.index;
    in_obj_x       <= it.ox;
    in_obj_y       <= it.oy;
    in_obj_radius  <= it.orad;
    in_obj_kind    <= it.okind;
    in_start_x     <= it.sx;
    in_start_y     <= it.sy;
    in_end_x       <= it.ex;
    in_end_y       <= it.ey;
    in_avoid_ball  <= it.avoid;
    in_margin      <= it.margin;
    start          <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transfer taken at this edge
    if (it.func == FUNC_WRITE) begin
      obst_mirror[it.index].kind   = it.okind;
      obst_mirror[it.index].x      = it.ox;
      obst_mirror[it.index].y      = it.oy;
      obst_mirror[it.index].radius = it.orad;
      n_writes++;
    end else begin
      pending_hits = {pending_hits, nearest_blocker(it)};
      if (pending_hits[$].found) n_blocked++;
      n_queries++;
    end
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold the sender until every owed answer has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so every out_valid cycle is
  // a transfer and must match the oldest owed answer.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    hit_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_hits.size() == 0) begin
        flag_mismatch($sformatf("unexpected result found=%0b index=%0d",
                                out_found, out_closest_index));
      end else begin
        want = pending_hits.pop_front();
        if (out_found !== want.found || out_closest_index !== want.idx) begin
          flag_mismatch($sformatf("found exp %0b got %0b, index exp %0d got %0d",
                                  want.found, out_found, want.idx, out_closest_index));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Give every entry a centre and radius before the first query so the scan
  // never evaluates storage that was only cleared, not written.
  task automatic test_table_init();
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      send_item(write_item(i, longint'($signed(COORD_W'($urandom))),
                           longint'($signed(COORD_W'($urandom))),
                           $urandom_range(0, 8191), KIND_EMPTY));
    end
  endtask

  // Holes and empties never block, balls only with avoid set, equal
  // distances go to the lower index, zero-length segments find nothing.
  task automatic test_kind_rules();
    send_item(write_item(0, 1600, 0, 160, KIND_SOLID));
    send_item(write_item(1, 800, 0, 160, KIND_HOLE));
    send_item(write_item(2, 400, 0, 80, KIND_BALL));
    send_item(write_item(3, 1600, 0, 160, KIND_SOLID));
    send_item(query_item(0, 0, 3200, 0, 1'b0, 0));
    send_item(query_item(0, 0, 3200, 0, 1'b1, 0));
    send_item(query_item(1600, 0, 1600, 0, 1'b1, 0));
    send_item(query_item(3200, 0, 0, 0, 1'b0, 0));
  endtask

  // Segments stopping short: inside a solid still blocks, inside a ball
  // short of its centre does not, well before a solid does not.
  task automatic test_endpoint_rules();
    send_item(query_item(0, 0, 1550, 0, 1'b0, 0));
    send_item(query_item(0, 0, 390, 0, 1'b1, 0));
    send_item(query_item(0, 0, 1300, 0, 1'b0, 0));
  endtask

  // A pass just outside the radius misses until the margin grows it.
  task automatic test_margin_growth();
    send_item(query_item(0, 200, 3200, 200, 1'b0, 0));
    send_item(query_item(0, 200, 3200, 200, 1'b0, 80));
    send_item(query_item(0, 200, 3200, 200, 1'b1, 8191));
  endtask

  // Corner coordinates, largest radius and margin, zero radius.
  task automatic test_extremes();
    send_item(write_item(31, -32768, -32768, 8191, KIND_SOLID));
    send_item(write_item(30, 32767, 32767, 0, KIND_BALL));
    send_item(query_item(32767, -32768, -32768, -32768, 1'b1, 8191));
    send_item(query_item(-32768, 32767, 32767, 32767, 1'b1, 0));
    send_item(query_item(-32768, -32768, 32767, 32767, 1'b1, 8191));
  endtask

  // Random scenes: a cluster of obstacles in one region, then mostly
  // queries, many aimed through stored centres, with stray writes and noise.
  task automatic test_random_scenes(input int n_items, input bit allow_idle);
    int sent, n_w, n_q, spread, j, k, pick;
    bit idle_on;
    longint cx, cy, sx, sy, ex, ey;
    logic [KIND_W-1:0] kind;
    item_t it;
    sent = 0;
    while (sent < n_items) begin
      spread  = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(256, 4096);
      cx      = longint'($urandom_range(0, 65535)) - 32768;
      cy      = longint'($urandom_range(0, 65535)) - 32768;
      idle_on = allow_idle && ($urandom_range(0, 2) != 0);
      n_w     = $urandom_range(4, 12);
      n_q     = $urandom_range(15, 40);
      for (int n = 0; n < n_w + n_q && sent < n_items; n++) begin
        pick = $urandom_range(0, 99);
        if (n < n_w || pick < 8) begin
          k = $urandom_range(0, 9);
          kind = (k == 0) ? KIND_EMPTY : (k < 3) ? KIND_HOLE :
                 (k < 7) ? KIND_SOLID : KIND_BALL;
          it = write_item($urandom_range(0, ENTRIES_DEF - 1),
                          near_point(cx, spread), near_point(cy, spread),
                          ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                      : $urandom_range(0, spread / 4),
                          kind);
        end else if (pick < 16) begin
          it = noise_item();
        end else begin
          sx = near_point(cx, spread);
          sy = near_point(cy, spread);
          if (pick < 20) begin
            ex = sx;
            ey = sy;
          end else if (pick < 70) begin
            // aim through a stored centre, ending anywhere from the centre
            // itself to well beyond it
            j  = $urandom_range(0, ENTRIES_DEF - 1);
            k  = $urandom_range(0, 8);
            ex = longint'($signed(obst_mirror[j].x));
            ey = longint'($signed(obst_mirror[j].y));
            ex = ex + (ex - sx) * k / 4 + longint'($urandom_range(0, 64)) - 32;
            ey = ey + (ey - sy) * k / 4 + longint'($urandom_range(0, 64)) - 32;
          end else begin
            ex = near_point(cx, spread);
            ey = near_point(cy, spread);
          end
          it = query_item(sx, sy, ex, ey, 1'($urandom),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                      : $urandom_range(0, spread / 8));
        end
        send_item(it);
        sent++;
        if (idle_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 9));
      end
      if (allow_idle && $urandom_range(0, 3) == 0) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    for (int i = 0; i < ENTRIES_DEF; i++) obst_mirror[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_init();
    test_kind_rules();
    test_endpoint_rules();
    test_margin_growth();
    test_extremes();
    wait_drained();
    test_random_scenes(1450, 1'b1);
    test_random_scenes(150, 1'b0);   // closing stretch, sender never idles

    wait_drained();
    repeat (ENTRIES_DEF + 16) @(posedge clk);

    $display("Covered %0d table writes and %0d segment queries, %0d of them blocked.",
             n_writes, n_queries, n_blocked);
    $display("%0d results checked, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

### files.f
design/scno_pkg.sv
design/scno_table.sv
design/scno_eval.sv
design/segment_circle_nearest_obstacle_unit.sv
sim/tb.sv
